// ----- src/accel_step_counter_assert.svh -----
// Assertion macros for the step counter RTL.
// No dependencies; included by modules that carry checks.
`ifndef ACCEL_STEP_COUNTER_ASSERT_SVH
`define ACCEL_STEP_COUNTER_ASSERT_SVH

// same-cycle implication
`define ASC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("step counter check failed");

// next-cycle implication
`define ASC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("step counter check failed");

`endif

// ----- src/asc_pkg.sv -----
// Shared constants, types and the FIR coefficient table for the step counter.
// No dependencies.
`default_nettype none

package asc_pkg;

    localparam int MagW      = 32;
    localparam int RootW     = 16;
    localparam int ShiftedW  = RootW - 5;
    localparam int SampleW   = 8;
    localparam int CoefW     = 8;
    localparam int ProdW     = SampleW + CoefW;
    localparam int TapCount  = 7;
    localparam int TapIdxW   = 3;
    localparam int AccW      = 17;
    localparam int FiltW     = 16;
    localparam int ThrW      = 13;
    localparam int GapW      = 8;
    localparam int HeldW     = 5;
    localparam int CntW      = 4;
    localparam int SqrtSteps = 16;
    localparam int CfgIdxW   = 8;
    localparam int CfgDataW  = 13;
    localparam int OutTdataW = 8;

    localparam logic [RootW-1:0]    RootTopBit  = 16'h8000;
    localparam logic [ShiftedW-1:0] ClampHiIn   = 11'd383;
    localparam logic [ShiftedW-1:0] ClampLoIn   = 11'd128;
    localparam logic signed [SampleW-1:0] SampleMax = 8'sd127;
    localparam logic signed [SampleW-1:0] SampleMin = -8'sd128;
    localparam logic [GapW-1:0]     GapMax      = 8'd255;
    localparam logic [HeldW-1:0]    HeldMax     = 5'd31;

    localparam logic [CfgIdxW-1:0] CfgPeakThreshold = 8'd0;
    localparam logic [CfgIdxW-1:0] CfgMinStepGap    = 8'd1;
    localparam logic [CfgIdxW-1:0] CfgMaxStepGap    = 8'd2;
    localparam logic [CfgIdxW-1:0] CfgStepsConfirm  = 8'd3;

    localparam logic [ThrW-1:0]  RstPeakThreshold = 13'd300;
    localparam logic [GapW-1:0]  RstMinStepGap    = 8'd4;
    localparam logic [GapW-1:0]  RstMaxStepGap    = 8'd16;
    localparam logic [HeldW-1:0] RstStepsConfirm  = 5'd5;

    typedef struct packed {
        logic [ThrW-1:0]  peak_threshold;
        logic [GapW-1:0]  min_step_gap;
        logic [GapW-1:0]  max_step_gap;
        logic [HeldW-1:0] steps_to_confirm;
    } cfg_t;

    typedef struct packed {
        logic               load;
        logic               sqrt_step;
        logic               ring_write;
        logic               fir_step;
        logic               decide;
        logic [TapIdxW-1:0] tap;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    function automatic logic signed [CoefW-1:0] tap_coef(input logic [TapIdxW-1:0] idx);
        logic signed [CoefW-1:0] c;
        case (idx)
            3'd0:    c = -8'sd11;
            3'd1:    c = -8'sd15;
            3'd2:    c = 8'sd44;
            3'd3:    c = 8'sd68;
            3'd4:    c = 8'sd44;
            3'd5:    c = -8'sd15;
            3'd6:    c = -8'sd11;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/asc_datapath.sv -----
// Datapath: iterative square root, sample ring with serial FIR, peak test,
// gait tracking and the output register. Depends on asc_pkg.
`default_nettype none

module asc_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire asc_pkg::cmd_t                 cmd,
    output asc_pkg::status_t                   status,
    input  wire asc_pkg::cfg_t                 cfg,
    input  wire logic [asc_pkg::MagW-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [asc_pkg::OutTdataW-1:0]      m_tdata
);

    typedef enum logic [3:0] {
        G_STILL    = 4'b0001,
        G_STEP1    = 4'b0010,
        G_COUNTING = 4'b0100,
        G_STEPPING = 4'b1000
    } gait_t;

    logic [asc_pkg::MagW-1:0]            x_reg;
    logic [asc_pkg::RootW-1:0]           root_reg, root_next;
    logic [asc_pkg::RootW-1:0]           mask_reg;
    logic [asc_pkg::RootW-1:0]           trial;
    logic [asc_pkg::MagW-1:0]            trial_sq;

    logic signed [asc_pkg::SampleW-1:0]  ring_reg [asc_pkg::TapCount];
    logic [asc_pkg::TapIdxW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [asc_pkg::ShiftedW-1:0]        shifted;
    logic signed [asc_pkg::SampleW-1:0]  sample;
    logic signed [asc_pkg::ProdW-1:0]    prod;
    logic signed [asc_pkg::AccW-1:0]     acc_reg;

    logic signed [asc_pkg::FiltW-1:0]    f_newest_reg, f_prev_reg;
    logic signed [asc_pkg::FiltW-1:0]    f_new;
    logic signed [asc_pkg::AccW-1:0]     f_new_ext, thr_ext;
    logic                                candidate;

    gait_t                               gait_reg, gait_next;
    logic [asc_pkg::HeldW-1:0]           held_reg, held_next, held_inc;
    logic [asc_pkg::GapW-1:0]            gap_reg, gap_inc;
    logic                                in_time;
    logic [asc_pkg::HeldW-1:0]           added;

    logic                                m_tvalid_reg;
    logic [asc_pkg::HeldW-1:0]           steps_reg;

    // square root: one trial bit per step
    assign trial    = root_reg | mask_reg;
    assign trial_sq = asc_pkg::MagW'(trial) * asc_pkg::MagW'(trial);
    assign root_next = (x_reg >= trial_sq) ? trial : root_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg    <= s_tdata;
            root_reg <= '0;
            mask_reg <= asc_pkg::RootTopBit;
        end else if (cmd.sqrt_step) begin
            root_reg <= root_next;
            mask_reg <= mask_reg >> 1;
        end
    end

    // offset, scale and clamp to a signed byte
    assign shifted = root_reg[asc_pkg::RootW-1:5];
    always_comb begin
        if (shifted >= asc_pkg::ClampHiIn) begin
            sample = asc_pkg::SampleMax;
        end else if (shifted < asc_pkg::ClampLoIn) begin
            sample = asc_pkg::SampleMin;
        end else begin
            sample = signed'(shifted[asc_pkg::SampleW-1:0]);
        end
    end

    assign prod = ring_reg[rd_ptr_reg] * asc_pkg::tap_coef(cmd.tap);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < asc_pkg::TapCount; i++) begin
                ring_reg[i] <= '0;
            end
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else if (cmd.ring_write) begin
            ring_reg[wr_ptr_reg] <= sample;
            rd_ptr_reg <= wr_ptr_reg;
            wr_ptr_reg <= (wr_ptr_reg == asc_pkg::TapIdxW'(asc_pkg::TapCount - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end else if (cmd.fir_step) begin
            rd_ptr_reg <= (rd_ptr_reg == '0) ?
                          asc_pkg::TapIdxW'(asc_pkg::TapCount - 1) : rd_ptr_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ring_write) begin
            acc_reg <= '0;
        end else if (cmd.fir_step) begin
            acc_reg <= acc_reg + asc_pkg::AccW'(prod);
        end
    end

    // floor divide by four
    assign f_new     = {acc_reg[asc_pkg::AccW-1], acc_reg[asc_pkg::AccW-1:2]};
    assign f_new_ext = asc_pkg::AccW'(f_new);
    assign thr_ext   = signed'({4'b0000, cfg.peak_threshold});
    assign candidate = (f_newest_reg > f_prev_reg) && (f_newest_reg > f_new) &&
                       (f_new_ext > thr_ext);

    assign gap_inc  = (gap_reg == asc_pkg::GapMax) ? gap_reg : gap_reg + 1'b1;
    assign in_time  = (gap_inc >= cfg.min_step_gap) && (gap_inc <= cfg.max_step_gap);
    assign held_inc = (held_reg < asc_pkg::HeldMax) ? held_reg + 1'b1 : held_reg;

    always_comb begin
        gait_next = gait_reg;
        held_next = held_reg;
        added     = '0;
        if (candidate) begin
            case (gait_reg)
                G_STILL: begin
                    gait_next = G_STEP1;
                    held_next = 5'd1;
                end
                G_STEP1: begin
                    held_next = in_time ? 5'd2 : 5'd1;
                    if (in_time) begin
                        gait_next = G_COUNTING;
                    end
                end
                G_COUNTING: begin
                    if (in_time) begin
                        held_next = held_inc;
                        if (held_inc >= cfg.steps_to_confirm) begin
                            gait_next = G_STEPPING;
                            added     = cfg.steps_to_confirm;
                        end
                    end else begin
                        gait_next = G_STEP1;
                    end
                end
                G_STEPPING: begin
                    if (in_time) begin
                        added = 5'd1;
                    end else begin
                        gait_next = G_STEP1;
                    end
                end
                default: begin
                    gait_next = G_STILL;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_newest_reg <= '0;
            f_prev_reg   <= '0;
            gait_reg     <= G_STILL;
            held_reg     <= '0;
            gap_reg      <= '0;
        end else if (cmd.decide) begin
            f_prev_reg   <= f_newest_reg;
            f_newest_reg <= f_new;
            gait_reg     <= gait_next;
            held_reg     <= held_next;
            gap_reg      <= candidate ? '0 : gap_inc;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.decide) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            steps_reg <= added;
        end
    end

    assign status.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = {(asc_pkg::OutTdataW - asc_pkg::HeldW)'(0), steps_reg};

endmodule

`default_nettype wire

// ----- src/asc_ctrl.sv -----
// Sequencer: steps each item through root, ring write, filter and decision.
// Depends on asc_pkg and accel_step_counter_assert.svh.
`default_nettype none

`include "accel_step_counter_assert.svh"

module asc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire asc_pkg::status_t  status,
    output asc_pkg::cmd_t          cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SQRT   = 5'b00010,
        S_WRITE  = 5'b00100,
        S_FIR    = 5'b01000,
        S_DECIDE = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [asc_pkg::CntW-1:0]  cnt_reg, cnt_next;

    localparam logic [asc_pkg::CntW-1:0] SqrtLast = asc_pkg::CntW'(asc_pkg::SqrtSteps - 1);
    localparam logic [asc_pkg::CntW-1:0] TapLast  = asc_pkg::CntW'(asc_pkg::TapCount - 1);

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd.load       = s_tvalid && (state_reg == S_IDLE);
        cmd.sqrt_step  = (state_reg == S_SQRT);
        cmd.ring_write = (state_reg == S_WRITE);
        cmd.fir_step   = (state_reg == S_FIR);
        cmd.decide     = (state_reg == S_DECIDE) && !status.out_busy;
        cmd.tap        = cnt_reg[asc_pkg::TapIdxW-1:0];
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SQRT;
                    cnt_next   = '0;
                end
            end
            S_SQRT: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SqrtLast) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                state_next = S_FIR;
                cnt_next   = '0;
            end
            S_FIR: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == TapLast) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!status.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `ASC_ASSERT_NEXT(a_load_starts_root, aclk, aresetn, cmd.load, (state_reg == S_SQRT) && (cnt_reg == '0))
    `ASC_ASSERT_NEXT(a_root_to_write, aclk, aresetn, (state_reg == S_SQRT) && (cnt_reg == SqrtLast), state_reg == S_WRITE)
    `ASC_ASSERT_NEXT(a_fir_runs_all_taps, aclk, aresetn, (state_reg == S_FIR) && (cnt_reg != TapLast), state_reg == S_FIR)
    `ASC_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.decide, !status.out_busy)

endmodule

`default_nettype wire

// ----- src/accel_step_counter.sv -----
// Step counter top level: configuration registers, sequencer and datapath.
// Depends on asc_pkg, asc_ctrl and asc_datapath.
//
// Usage:
//   s_ channel: one squared accelerometer magnitude per item on s_tdata.
//   m_ channel: one result item per input item; m_tdata[4:0] holds the steps
//   credited by that sample (0, 1, or the confirm count when a run is confirmed).
//   cfg channel: register writes, index 0 peak threshold, 1 min gap, 2 max gap,
//   3 steps to confirm; other indexes are ignored. cfg_ready is always high.
// Timing: s_tready returns once the decision step has completed, so an item is
//   taken only after the previous one is through; the steps are the bit-serial
//   square root (one 16x16 multiply per step), a ring write, the FIR that shares
//   one 8x8 multiplier over the taps and a decision step, which holds while the
//   output is stalled. The result is held in the output register until taken.
// Reset (aresetn low, synchronous): filter ring, filter history, gait state and
//   gap counter clear; registers return to 300, 4, 16, 5.
// Stall: a result waits in the output register; the next item is still taken,
//   and its decision step holds until the previous result has gone.
`default_nettype none

module accel_step_counter (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [asc_pkg::MagW-1:0]       s_tdata,     // [31:0] mag_squared
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [asc_pkg::OutTdataW-1:0]       m_tdata,     // [4:0] steps_added, [7:5] zero
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [asc_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [asc_pkg::CfgDataW-1:0]   cfg_data
);

    asc_pkg::cfg_t    cfg_reg;
    asc_pkg::cmd_t    cmd;
    asc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.peak_threshold   <= asc_pkg::RstPeakThreshold;
            cfg_reg.min_step_gap     <= asc_pkg::RstMinStepGap;
            cfg_reg.max_step_gap     <= asc_pkg::RstMaxStepGap;
            cfg_reg.steps_to_confirm <= asc_pkg::RstStepsConfirm;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                asc_pkg::CfgPeakThreshold: begin
                    cfg_reg.peak_threshold <= cfg_data;
                end
                asc_pkg::CfgMinStepGap: begin
                    cfg_reg.min_step_gap <= cfg_data[asc_pkg::GapW-1:0];
                end
                asc_pkg::CfgMaxStepGap: begin
                    cfg_reg.max_step_gap <= cfg_data[asc_pkg::GapW-1:0];
                end
                asc_pkg::CfgStepsConfirm: begin
                    cfg_reg.steps_to_confirm <= cfg_data[asc_pkg::HeldW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    asc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    asc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
